FILE: hdl/ab_slot_record_policy_top_macros.svh
// Assertion macros for the A/B slot record policy block.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef AB_SLOT_RECORD_POLICY_TOP_MACROS_SVH
`define AB_SLOT_RECORD_POLICY_TOP_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked out of reset.
`define ABSRP_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("absrp implication check failed");

// Next-cycle implication, checked out of reset.
`define ABSRP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("absrp next-cycle check failed");

`else

`define ABSRP_ASSERT_IMPLY(lbl, ante, cons)
`define ABSRP_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

FILE: hdl/absrp_pkg.sv
// Shared types and codes for the A/B slot record policy block.
// No dependencies; used by the query and verdict interfaces and every module.
package absrp_pkg;

  localparam int SEQ_W = 32;

  typedef logic [SEQ_W-1:0] seq_t;

  typedef enum logic [1:0] {
    SLOT_VALID   = 2'd0,
    SLOT_ERASED  = 2'd1,
    SLOT_CORRUPT = 2'd2,
    SLOT_IOERR   = 2'd3
  } slot_state_t;

  typedef enum logic [1:0] {
    RD_OK        = 2'd0,
    RD_NOT_FOUND = 2'd1,
    RD_CORRUPT   = 2'd2,
    RD_IOERR     = 2'd3
  } read_status_t;

  typedef enum logic [2:0] {
    HL_HEALTHY     = 3'd0,
    HL_DEGRADED    = 3'd1,
    HL_DEGRADED_IO = 3'd2,
    HL_CORRUPT     = 3'd3,
    HL_IOERR       = 3'd4
  } health_t;

  typedef enum logic [1:0] {
    REC_ERASE_REWRITE = 2'd0,
    REC_NOT_NEEDED    = 2'd1,
    REC_IOERR         = 2'd2,
    REC_FAILED        = 2'd3
  } recover_t;

  localparam logic SEL_A = 1'b0;
  localparam logic SEL_B = 1'b1;

  typedef struct packed {
    slot_state_t slot_a_state;
    slot_state_t slot_b_state;
    seq_t        seq_a;
    seq_t        seq_b;
  } query_t;

  typedef struct packed {
    read_status_t read_status;
    logic         read_slot;
    health_t      health;
    logic         write_allowed;
    logic         prog_slot;
    seq_t         write_sequence;
    recover_t     recover_action;
  } verdict_t;

endpackage

FILE: hdl/absrp_ifs.sv
// Valid/ready channel interfaces for queries, verdicts and configuration.
// Depends on absrp_pkg.
interface absrp_in_if;
  import absrp_pkg::*;
  logic       valid;
  logic       ready;
  logic [1:0] slot_a_state;
  logic [1:0] slot_b_state;
  seq_t       seq_a;
  seq_t       seq_b;

  modport source (output valid, slot_a_state, slot_b_state, seq_a,
                  seq_b, input ready);
  modport sink   (input valid, slot_a_state, slot_b_state, seq_a,
                  seq_b, output ready);
endinterface

interface absrp_out_if;
  import absrp_pkg::*;
  logic       valid;
  logic       ready;
  logic [1:0] read_status;
  logic       read_slot;
  logic [2:0] health;
  logic       write_allowed;
  logic       prog_slot;
  seq_t       write_sequence;
  logic [1:0] recover_action;

  modport source (output valid, read_status, read_slot, health, write_allowed,
                  prog_slot, write_sequence, recover_action, input ready);
  modport sink   (input valid, read_status, read_slot, health, write_allowed,
                  prog_slot, write_sequence, recover_action, output ready);
endinterface

interface absrp_cfg_if;
  logic valid;
  logic ready;
  logic storage_ready;

  modport source (output valid, storage_ready, input ready);
  modport sink   (input valid, storage_ready, output ready);
endinterface

FILE: hdl/absrp_in_stage.sv
// Input register: captures one query per transfer and hands it downstream.
// Depends on absrp_pkg and absrp_in_if.
module absrp_in_stage (
  input  logic              clk,
  input  logic              rst_n,
  absrp_in_if.sink          in_chan,
  output logic              q_valid,
  output absrp_pkg::query_t q_item,
  input  logic              q_ready
);
  import absrp_pkg::*;

  logic   valid_r;
  query_t item_r;
  logic   take;

  assign in_chan.ready = !valid_r || q_ready;
  assign take          = in_chan.valid && in_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_chan.ready) begin
      valid_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item_r.slot_a_state <= slot_state_t'(in_chan.slot_a_state);
      item_r.slot_b_state <= slot_state_t'(in_chan.slot_b_state);
      item_r.seq_a        <= in_chan.seq_a;
      item_r.seq_b        <= in_chan.seq_b;
    end
  end

  assign q_valid = valid_r;
  assign q_item  = item_r;
endmodule

FILE: hdl/absrp_decide.sv
// Decision logic: read choice, health grade, write target and repair verdict.
// Depends on absrp_pkg.
module absrp_decide (
  input  logic                storage_ready,
  input  absrp_pkg::query_t   q_item,
  output absrp_pkg::verdict_t v_item
);
  import absrp_pkg::*;

  logic av, bv, ae, be, ac, bc, aio, bio, any_io;
  seq_t seq_diff;
  logic b_newer;
  seq_t base;
  seq_t seq_inc;
  verdict_t v;

  always_comb begin
    av     = (q_item.slot_a_state == SLOT_VALID);
    bv     = (q_item.slot_b_state == SLOT_VALID);
    ae     = (q_item.slot_a_state == SLOT_ERASED);
    be     = (q_item.slot_b_state == SLOT_ERASED);
    ac     = (q_item.slot_a_state == SLOT_CORRUPT);
    bc     = (q_item.slot_b_state == SLOT_CORRUPT);
    aio    = (q_item.slot_a_state == SLOT_IOERR);
    bio    = (q_item.slot_b_state == SLOT_IOERR);
    any_io = aio || bio;

    // Wrap-safe compare: B is newer when A - B is negative as a signed word.
    seq_diff = q_item.seq_a - q_item.seq_b;
    b_newer  = seq_diff[SEQ_W-1];

    v.read_slot      = SEL_A;
    v.write_allowed  = 1'b0;
    v.prog_slot      = SEL_A;
    v.write_sequence = '0;
    base             = '0;

    priority if (av && bv) begin
      v.read_status = RD_OK;
      v.read_slot   = b_newer;
    end else if (av) begin
      v.read_status = RD_OK;
    end else if (bv) begin
      v.read_status = RD_OK;
      v.read_slot   = SEL_B;
    end else if (any_io) begin
      v.read_status = RD_IOERR;
    end else if (ae && be) begin
      v.read_status = RD_NOT_FOUND;
    end else begin
      v.read_status = RD_CORRUPT;
    end

    priority if (av && bv) begin
      v.health = HL_HEALTHY;
    end else if ((av && bio) || (bv && aio)) begin
      v.health = HL_DEGRADED_IO;
    end else if (any_io) begin
      v.health = HL_IOERR;
    end else if (av || bv) begin
      v.health = HL_DEGRADED;
    end else if (ac || bc) begin
      v.health = HL_CORRUPT;
    end else begin
      v.health = HL_HEALTHY;
    end

    // Write goes to the older slot, or to the one that is not valid; fail closed on io error, or on a corrupt
    // slot with nothing valid.
    if (!any_io) begin
      priority if (ae && be) begin
        v.write_allowed = 1'b1;
      end else if (av && bv) begin
        v.write_allowed = 1'b1;
        v.prog_slot     = !b_newer;
        base            = b_newer ? q_item.seq_b : q_item.seq_a;
      end else if (av) begin
        v.write_allowed = 1'b1;
        v.prog_slot     = SEL_B;
        base            = q_item.seq_a;
      end else if (bv) begin
        v.write_allowed = 1'b1;
        base            = q_item.seq_b;
      end else begin
        v.write_allowed = 1'b0;
      end
    end

    // Skip zero on wrap.
    seq_inc = base + seq_t'(1);
    if (seq_inc == '0) begin
      seq_inc = seq_t'(1);
    end
    if (v.write_allowed) begin
      v.write_sequence = seq_inc;
    end

    priority if (any_io) begin
      v.recover_action = REC_IOERR;
    end else if (ac || bc) begin
      v.recover_action = (av && bv) ? REC_NOT_NEEDED : REC_ERASE_REWRITE;
    end else begin
      v.recover_action = REC_NOT_NEEDED;
    end

    // Storage not validated: report error everywhere.
    if (!storage_ready) begin
      v.read_status    = RD_IOERR;
      v.read_slot      = SEL_A;
      v.health         = HL_IOERR;
      v.write_allowed  = 1'b0;
      v.prog_slot      = SEL_A;
      v.write_sequence = '0;
      v.recover_action = REC_FAILED;
    end

    v_item = v;
  end
endmodule

FILE: hdl/absrp_out_stage.sv
// Result register: holds one verdict until the downstream transfer completes.
// Depends on absrp_pkg and absrp_out_if.
module absrp_out_stage (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                v_valid,
  input  absrp_pkg::verdict_t v_item,
  output logic                v_ready,
  absrp_out_if.source         out_chan
);
  import absrp_pkg::*;

  logic     valid_r;
  verdict_t item_r;

  assign v_ready = !valid_r || out_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (v_ready) begin
      valid_r <= v_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (v_ready && v_valid) begin
      item_r <= v_item;
    end
  end

  assign out_chan.valid          = valid_r;
  assign out_chan.read_status    = item_r.read_status;
  assign out_chan.read_slot      = item_r.read_slot;
  assign out_chan.health         = item_r.health;
  assign out_chan.write_allowed  = item_r.write_allowed;
  assign out_chan.prog_slot      = item_r.prog_slot;
  assign out_chan.write_sequence = item_r.write_sequence;
  assign out_chan.recover_action = item_r.recover_action;
endmodule

FILE: hdl/ab_slot_record_policy_top.sv
// Input register, decision logic and result register form a two-stage pipeline with
// ready chained back from the output; a query is registered in the first stage and its
// verdict in the second. Throughput: one query per cycle while the output stays ready.
// Reset (rst_n low, synchronous): both stages empty, storage_ready cleared to 0.
// Config writes are always accepted; the register is sampled by the decision logic.
`include "ab_slot_record_policy_top_macros.svh"

module ab_slot_record_policy_top (
  input  logic        clk,
  input  logic        rst_n,
  absrp_in_if.sink    in_chan,
  absrp_out_if.source out_chan,
  absrp_cfg_if.sink   cfg_chan
);
  import absrp_pkg::*;

  logic     storage_ready_r;
  logic     q_valid;
  query_t   q_item;
  logic     q_ready;
  verdict_t v_item;

  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      storage_ready_r <= 1'b0;
    end else if (cfg_chan.valid) begin
      storage_ready_r <= cfg_chan.storage_ready;
    end
  end

  absrp_in_stage u_in_stage (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_ready (q_ready)
  );

  absrp_decide u_decide (
    .storage_ready (storage_ready_r),
    .q_item        (q_item),
    .v_item        (v_item)
  );

  absrp_out_stage u_out_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .v_valid  (q_valid),
    .v_item   (v_item),
    .v_ready  (q_ready),
    .out_chan (out_chan)
  );

  `ABSRP_ASSERT_IMPLY(a_write_seq_nonzero, out_chan.valid && out_chan.write_allowed,
                      out_chan.write_sequence != '0)
  `ABSRP_ASSERT_IMPLY(a_fail_closed_zero, out_chan.valid && !out_chan.write_allowed,
                      out_chan.write_sequence == '0 && out_chan.prog_slot == SEL_A)
  `ABSRP_ASSERT_IMPLY(a_read_slot_ok_only, out_chan.valid && out_chan.read_status != RD_OK,
                      out_chan.read_slot == SEL_A)
  `ABSRP_ASSERT_NEXT(a_stage_fill, q_valid && q_ready, out_chan.valid)
endmodule

FILE: tb/tb.sv
// Self-checking bench for ab_slot_record_policy_top: a directed table, then random queries.
// Each verdict is predicted in the bench and checked in order, with idles on both channels.
// Depends on absrp_pkg, the channel interfaces in absrp_ifs.sv and the block's RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import absrp_pkg::*;

  typedef struct packed {
    logic     rdy;
    logic     typed;
    query_t   q;
    verdict_t v;
  } stim_row_t;

  localparam verdict_t NOT_READY_V =
    '{RD_IOERR, SEL_A, HL_IOERR, 1'b0, SEL_A, 32'd0, REC_FAILED};
  localparam verdict_t IO_ONLY_V =
    '{RD_IOERR, SEL_A, HL_IOERR, 1'b0, SEL_A, 32'd0, REC_IOERR};

  logic clk = 1'b0;
  logic rst_n;

  absrp_in_if  in_if();
  absrp_out_if out_if();
  absrp_cfg_if cfg_if();

  ab_slot_record_policy_top u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .cfg_chan (cfg_if)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  verdict_t verdicts_due[$];
  stim_row_t stim_rows[$];
  logic storage_ready_model = 1'b0;
  bit   idle_en = 1'b1;
  bit   quiet_tail = 1'b0;
  int   errors = 0;
  int   queries_sent = 0;
  int   queries_not_ready = 0;
  int   verdicts_checked = 0;
  int   cfg_writes = 0;
  int   stall_left = 0;

  function automatic verdict_t predict_verdict(input logic rdy, input query_t q);
    verdict_t v;
    logic av, bv, ae, be, ac, bc, aio, bio, b_newer;
    seq_t diff, base;
    v = '0;
    base = '0;
    if (!rdy) begin
      v.read_status    = RD_IOERR;
      v.health         = HL_IOERR;
      v.recover_action = REC_FAILED;
      return v;
    end
    av  = (q.slot_a_state == SLOT_VALID);
    bv  = (q.slot_b_state == SLOT_VALID);
    ae  = (q.slot_a_state == SLOT_ERASED);
    be  = (q.slot_b_state == SLOT_ERASED);
    ac  = (q.slot_a_state == SLOT_CORRUPT);
    bc  = (q.slot_b_state == SLOT_CORRUPT);
    aio = (q.slot_a_state == SLOT_IOERR);
    bio = (q.slot_b_state == SLOT_IOERR);
    // wrap-safe compare: sign of A - B, ties go to A
    diff = q.seq_a - q.seq_b;
    b_newer = diff[SEQ_W-1];

    if (av && bv) begin
      v.read_status = RD_OK;
      v.read_slot   = b_newer ? SEL_B : SEL_A;
    end else if (av) begin
      v.read_status = RD_OK;
    end else if (bv) begin
      v.read_status = RD_OK;
      v.read_slot   = SEL_B;
    end else if (aio || bio) v.read_status = RD_IOERR;
    else if (ae && be) v.read_status = RD_NOT_FOUND;
    else v.read_status = RD_CORRUPT;

    if (av && bv) v.health = HL_HEALTHY;
    else if ((av && bio) || (bv && aio)) v.health = HL_DEGRADED_IO;
    else if (aio || bio) v.health = HL_IOERR;
    else if (av || bv) v.health = HL_DEGRADED;
    else if (ac || bc) v.health = HL_CORRUPT;
    else v.health = HL_HEALTHY;

    if (!(aio || bio)) begin
      if (ae && be) begin
        v.write_allowed = 1'b1;
      end else if (av && bv) begin
        v.write_allowed = 1'b1;
        v.prog_slot     = b_newer ? SEL_A : SEL_B;
        base            = b_newer ? q.seq_b : q.seq_a;
      end else if (av) begin
        v.write_allowed = 1'b1;
        v.prog_slot     = SEL_B;
        base            = q.seq_a;
      end else if (bv) begin
        v.write_allowed = 1'b1;
        base            = q.seq_b;
      end
      if (v.write_allowed) begin
        v.write_sequence = base + 1'b1;
        if (v.write_sequence == '0) v.write_sequence = 32'd1;
      end
    end

    if (aio || bio) v.recover_action = REC_IOERR;
    else if ((av && bv) || (ae && be)) v.recover_action = REC_NOT_NEEDED;
    else if (!ac && !bc) v.recover_action = REC_NOT_NEEDED;
    else v.recover_action = REC_ERASE_REWRITE;
    return v;
  endfunction

  function automatic stim_row_t mk_row(input logic rdy, input logic typed,
                                       input slot_state_t a, input slot_state_t b,
                                       input seq_t sa, input seq_t sb, input verdict_t v);
    stim_row_t r;
    r.rdy = rdy;
    r.typed = typed;
    r.q.slot_a_state = a;
    r.q.slot_b_state = b;
    r.q.seq_a = sa;
    r.q.seq_b = sb;
    r.v = v;
    return r;
  endfunction

  function automatic slot_state_t rand_state();
    // lean toward valid so the sequence comparison gets plenty of traffic
    return ($urandom_range(0, 9) < 5) ? SLOT_VALID : slot_state_t'($urandom_range(0, 3));
  endfunction

  function automatic query_t rand_query();
    query_t q;
    q.slot_a_state = rand_state();
    q.slot_b_state = rand_state();
    q.seq_a = $urandom;
    case ($urandom_range(0, 5))
      0: q.seq_b = $urandom;
      1: q.seq_b = q.seq_a;
      2: q.seq_b = q.seq_a + $urandom_range(1, 4);
      3: q.seq_b = q.seq_a - $urandom_range(1, 4);
      4: q.seq_b = q.seq_a ^ 32'h8000_0000;
      default: begin
        q.seq_a = 32'hFFFF_FFFF - $urandom_range(0, 2);
        q.seq_b = $urandom_range(0, 2);
        if ($urandom_range(0, 1)) begin
          q.seq_b = q.seq_a;
          q.seq_a = $urandom_range(0, 2);
        end
      end
    endcase
    return q;
  endfunction

  task automatic send_query(input query_t q, input logic typed, input verdict_t typed_v);
    if (idle_en && $urandom_range(0, 4) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_if.valid        <= 1'b1;
    in_if.slot_a_state <= q.slot_a_state;
    in_if.slot_b_state <= q.slot_b_state;
    in_if.seq_a        <= q.seq_a;
    in_if.seq_b        <= q.seq_b;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    verdicts_due.push_back(typed ? typed_v : predict_verdict(storage_ready_model, q));
    queries_sent++;
    if (!storage_ready_model) queries_not_ready++;
  endtask

  task automatic write_storage_ready(input logic val);
    // drop valid and wait for the pipeline to drain before touching the register
    in_if.valid <= 1'b0;
    while (verdicts_due.size() != 0) @(posedge clk);
    cfg_if.valid         <= 1'b1;
    cfg_if.storage_ready <= val;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    cfg_if.valid <= 1'b0;
    storage_ready_model = val;
    cfg_writes++;
  endtask

  task automatic run_random(input int n);
    for (int i = 0; i < n; i++) begin
      idle_en = !quiet_tail && ((i % 100) < 70);
      send_query(rand_query(), 1'b0, '0);
    end
  endtask

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    verdict_t exp_v;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (verdicts_due.size() == 0) begin
        errors++;
        $display("%0t: verdict transfer with nothing expected: expected none, actual 0x%0h",
                 $time, {out_if.read_status, out_if.read_slot, out_if.health,
                         out_if.write_allowed, out_if.prog_slot, out_if.write_sequence,
                         out_if.recover_action});
      end else begin
        exp_v = verdicts_due.pop_front();
        check_field("read_status", 32'(exp_v.read_status), 32'(out_if.read_status));
        check_field("read_slot", 32'(exp_v.read_slot), 32'(out_if.read_slot));
        check_field("health", 32'(exp_v.health), 32'(out_if.health));
        check_field("write_allowed", 32'(exp_v.write_allowed), 32'(out_if.write_allowed));
        check_field("prog_slot", 32'(exp_v.prog_slot), 32'(out_if.prog_slot));
        check_field("write_sequence", exp_v.write_sequence, out_if.write_sequence);
        check_field("recover_action", 32'(exp_v.recover_action),
                    32'(out_if.recover_action));
        verdicts_checked++;
      end
    end
  end

  // result side back-pressure in short random bursts
  initial begin
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left != 0) begin
        out_if.ready <= 1'b0;
        stall_left--;
      end else if (idle_en && $urandom_range(0, 4) == 0) begin
        out_if.ready <= 1'b0;
        stall_left = $urandom_range(0, 2);
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  initial begin
    #200000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    rst_n                <= 1'b0;
    in_if.valid          <= 1'b0;
    in_if.slot_a_state   <= SLOT_VALID;
    in_if.slot_b_state   <= SLOT_VALID;
    in_if.seq_a          <= '0;
    in_if.seq_b          <= '0;
    cfg_if.valid         <= 1'b0;
    cfg_if.storage_ready <= 1'b0;

    // not ready after reset, then every pair of slot classes, then the wrap corners
    stim_rows.push_back(mk_row(1'b0, 1'b1, SLOT_IOERR, SLOT_IOERR,
                               32'hFFFF_FFFF, 32'hFFFF_FFFF, NOT_READY_V));
    stim_rows.push_back(mk_row(1'b0, 1'b1, SLOT_VALID, SLOT_VALID, 32'd0, 32'd0,
                               NOT_READY_V));
    stim_rows.push_back(mk_row(1'b1, 1'b0, SLOT_VALID, SLOT_VALID,
                               32'h1234_5678, 32'hA5A5_A5A5, '0));
    stim_rows.push_back(mk_row(1'b1, 1'b0, SLOT_VALID, SLOT_ERASED,
                               32'h1234_5678, 32'hFFFF_FFFF, '0));
    stim_rows.push_back(mk_row(1'b1, 1'b0, SLOT_VALID, SLOT_CORRUPT,
                               32'h0000_0000, 32'h5555_5555, '0));
    stim_rows.push_back(mk_row(1'b1, 1'b1, SLOT_VALID, SLOT_IOERR,
                               32'hFFFF_FFFF, 32'hFFFF_FFFF,
                               '{RD_OK, SEL_A, HL_DEGRADED_IO, 1'b0, SEL_A, 32'd0,
                                 REC_IOERR}));
    stim_rows.push_back(mk_row(1'b1, 1'b0, SLOT_ERASED, SLOT_VALID,
                               32'hFFFF_FFFF, 32'h7FFF_FFFE, '0));
    stim_rows.push_back(mk_row(1'b1, 1'b1, SLOT_ERASED, SLOT_ERASED,
                               32'hFFFF_FFFF, 32'hFFFF_FFFF,
                               '{RD_NOT_FOUND, SEL_A, HL_HEALTHY, 1'b1, SEL_A, 32'd1,
                                 REC_NOT_NEEDED}));
    stim_rows.push_back(mk_row(1'b1, 1'b0, SLOT_ERASED, SLOT_CORRUPT,
                               32'h0F0F_0F0F, 32'hF0F0_F0F0, '0));
    stim_rows.push_back(mk_row(1'b1, 1'b1, SLOT_ERASED, SLOT_IOERR,
                               32'd0, 32'd0, IO_ONLY_V));
    stim_rows.push_back(mk_row(1'b1, 1'b0, SLOT_CORRUPT, SLOT_VALID,
                               32'h1111_1111, 32'h0000_0001, '0));
    stim_rows.push_back(mk_row(1'b1, 1'b0, SLOT_CORRUPT, SLOT_ERASED,
                               32'h2222_2222, 32'h3333_3333, '0));
    stim_rows.push_back(mk_row(1'b1, 1'b1, SLOT_CORRUPT, SLOT_CORRUPT,
                               32'hFFFF_FFFF, 32'd0,
                               '{RD_CORRUPT, SEL_A, HL_CORRUPT, 1'b0, SEL_A, 32'd0,
                                 REC_ERASE_REWRITE}));
    stim_rows.push_back(mk_row(1'b1, 1'b1, SLOT_CORRUPT, SLOT_IOERR,
                               32'd0, 32'hFFFF_FFFF, IO_ONLY_V));
    stim_rows.push_back(mk_row(1'b1, 1'b1, SLOT_IOERR, SLOT_VALID,
                               32'hFFFF_FFFF, 32'hFFFF_FFFF,
                               '{RD_OK, SEL_B, HL_DEGRADED_IO, 1'b0, SEL_A, 32'd0,
                                 REC_IOERR}));
    stim_rows.push_back(mk_row(1'b1, 1'b1, SLOT_IOERR, SLOT_ERASED,
                               32'hFFFF_FFFF, 32'd0, IO_ONLY_V));
    stim_rows.push_back(mk_row(1'b1, 1'b1, SLOT_IOERR, SLOT_CORRUPT,
                               32'd0, 32'd0, IO_ONLY_V));
    stim_rows.push_back(mk_row(1'b1, 1'b1, SLOT_IOERR, SLOT_IOERR,
                               32'hFFFF_FFFF, 32'hFFFF_FFFF, IO_ONLY_V));
    // A at the top of the range, B just past the wrap: B is newer
    stim_rows.push_back(mk_row(1'b1, 1'b0, SLOT_VALID, SLOT_VALID,
                               32'hFFFF_FFFF, 32'd0, '0));
    stim_rows.push_back(mk_row(1'b1, 1'b0, SLOT_VALID, SLOT_VALID,
                               32'h8000_0000, 32'd0, '0));
    stim_rows.push_back(mk_row(1'b1, 1'b0, SLOT_VALID, SLOT_VALID,
                               32'h7FFF_FFFF, 32'h7FFF_FFFF, '0));
    // increment from all ones skips zero
    stim_rows.push_back(mk_row(1'b1, 1'b1, SLOT_VALID, SLOT_ERASED,
                               32'hFFFF_FFFF, 32'd0,
                               '{RD_OK, SEL_A, HL_DEGRADED, 1'b1, SEL_B, 32'd1,
                                 REC_NOT_NEEDED}));
    stim_rows.push_back(mk_row(1'b1, 1'b0, SLOT_CORRUPT, SLOT_VALID,
                               32'd0, 32'hFFFF_FFFF, '0));

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (stim_rows[i]) begin
      if (stim_rows[i].rdy != storage_ready_model) write_storage_ready(stim_rows[i].rdy);
      send_query(stim_rows[i].q, stim_rows[i].typed, stim_rows[i].v);
    end

    run_random(300);
    write_storage_ready(1'b0);
    run_random(100);
    write_storage_ready(1'b1);
    run_random(300);
    quiet_tail = 1'b1;
    idle_en = 1'b0;
    run_random(100);
    in_if.valid <= 1'b0;

    while (verdicts_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);

    $display("Sent %0d queries (%0d with storage not ready), checked %0d verdicts",
             queries_sent, queries_not_ready, verdicts_checked);
    $display("Storage-ready register written %0d times; %0d mismatches", cfg_writes, errors);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+hdl
hdl/absrp_pkg.sv
hdl/absrp_ifs.sv
hdl/absrp_in_stage.sv
hdl/absrp_decide.sv
hdl/absrp_out_stage.sv
hdl/ab_slot_record_policy_top.sv
tb/tb.sv
